// ----- design/dapm_pkg.sv -----
// Shared types and constants for the dual-axis PID leveling mixer.
`default_nettype none

package dapm_pkg;

  localparam int unsigned GainW   = 24;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned SumW    = 40;
  localparam int unsigned LimW    = 13;
  localparam int unsigned TicksW  = 8;
  localparam int unsigned TickW   = 9;
  localparam int unsigned TermW   = 49;
  localparam int unsigned CfgIdxW = 3;

  // Register reset values
  localparam logic [GainW-1:0]  KpReset     = 24'd1966080;
  localparam logic [GainW-1:0]  KiReset     = 24'd6554;
  localparam logic [GainW-1:0]  KdReset     = 24'd65536;
  localparam logic [LimW-1:0]   LimReset    = 13'd2000;
  localparam logic [TicksW-1:0] TicksReset  = 8'd100;

  // Motor offsets
  localparam logic signed [16:0] OfsOne   = 17'sd49100;
  localparam logic signed [14:0] OfsTwo   = -15'sd2000;
  localparam logic signed [14:0] OfsThree = -15'sd2000;
  localparam logic signed [14:0] OfsFour  = 15'sd2000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKpPitch      = 3'd0,
    CfgKiPitch      = 3'd1,
    CfgKdPitch      = 3'd2,
    CfgKpRoll       = 3'd3,
    CfgKiRoll       = 3'd4,
    CfgKdRoll       = 3'd5,
    CfgClampLimit   = 3'd6,
    CfgStartupTicks = 3'd7
  } cfg_reg_e;

  // Load enables of the datapath stages behind the input register
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

`default_nettype wire

// ----- design/dapm_pid_axis.sv -----
// Three-stage PID term datapath for one axis: products, partial sums, final round.
`default_nettype none

module dapm_pid_axis (
  input  wire                                        clk_i,
  input  wire dapm_pkg::stage_en_t                   en_i,
  input  wire logic signed [dapm_pkg::AngleW-1:0]    x_i,
  input  wire logic signed [dapm_pkg::AngleW-1:0]    prev_i,
  input  wire logic signed [dapm_pkg::SumW-1:0]      sum_i,
  input  wire logic        [dapm_pkg::GainW-1:0]     kp_i,
  input  wire logic        [dapm_pkg::GainW-1:0]     ki_i,
  input  wire logic        [dapm_pkg::GainW-1:0]     kd_i,
  output logic signed      [dapm_pkg::TermW-1:0]     term_o
);

  localparam logic signed [64:0] IpLimPos = 65'sd1 <<< 62;
  localparam logic signed [64:0] IpLimNeg = -(65'sd1 <<< 62);

  logic signed [24:0] kp_s, ki_s, kd_s;
  logic signed [16:0] diff;

  logic signed [40:0] prod_p_d, prod_p_q;
  logic signed [41:0] prod_d_d, prod_d_q;
  logic        [43:0] prod_lo_d, prod_lo_q;
  logic signed [44:0] prod_hi_d, prod_hi_q;

  logic signed [64:0] ip_full;
  logic signed [63:0] ip_d, ip_q;
  logic signed [43:0] pd_d, pd_q;

  logic signed [64:0] total;
  logic signed [dapm_pkg::TermW-1:0] term_d, term_q;

  // Stage 1: split the integral product at bit 20 of the sum
  assign kp_s      = $signed({1'b0, kp_i});
  assign ki_s      = $signed({1'b0, ki_i});
  assign kd_s      = $signed({1'b0, kd_i});
  assign diff      = 17'(x_i) - 17'(prev_i);
  assign prod_p_d  = 41'(kp_s) * 41'(x_i);
  assign prod_d_d  = 42'(kd_s) * 42'(diff);
  assign prod_lo_d = 44'(ki_i) * 44'(sum_i[19:0]);
  assign prod_hi_d = 45'(ki_s) * 45'($signed(sum_i[39:20]));

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      prod_p_q  <= prod_p_d;
      prod_d_q  <= prod_d_d;
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
    end
  end

  // Stage 2: rebuild and limit the integral product, add P, D and the rounding half
  assign ip_full = (65'(prod_hi_q) <<< 20) + $signed({21'b0, prod_lo_q});

  always_comb begin
    priority if (ip_full > IpLimPos) begin
      ip_d = 64'(IpLimPos);
    end else if (ip_full < IpLimNeg) begin
      ip_d = 64'(IpLimNeg);
    end else begin
      ip_d = 64'(ip_full);
    end
  end

  assign pd_d = 44'(prod_p_q) + 44'(prod_d_q) + 44'sd32768;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      ip_q <= ip_d;
      pd_q <= pd_d;
    end
  end

  // Stage 3: full sum, floor shift by 16
  assign total  = 65'(ip_q) + 65'(pd_q);
  assign term_d = total[64:16];

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

`default_nettype wire

// ----- design/dual_axis_pid_leveling_mixer_core.sv -----
// Top level of the dual-axis PID leveling mixer: state, pipeline control, motor mix.
//
// One input transfer carries a pitch and a roll sample; one output transfer carries
// the four motor targets and the startup flag. Both channels use valid/stall: a
// transfer happens on a clock edge with valid high and stall low.
// Gains, clamp limit and startup length are written through the cfg_we_i port,
// one register per write; the user must write them only while no sample is in
// flight, as the block itself does not enforce it. Throughput: one sample per
// cycle while the output is not stalled; the pipeline is input register, PID
// products, partial sums, final round, then the mix/clamp output register.
// The integrators, previous samples and tick counter update at the input transfer.
// While the tick counter is at or below startup_ticks, the output carries only the
// fixed offsets with in_startup_o set.
// Reset restores register defaults, clears state and empties the pipeline.
// A stalled output holds; earlier stages keep filling, and in_stall_o rises only
// once every stage holds a sample.
`default_nettype none

module dual_axis_pid_leveling_mixer_core (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       cfg_we_i,
  input  wire logic [dapm_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [dapm_pkg::GainW-1:0]           cfg_wdata_i,
  input  wire                                       in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [dapm_pkg::AngleW-1:0]   pitch_angle_i,
  input  wire logic signed [dapm_pkg::AngleW-1:0]   roll_angle_i,
  output logic                                      out_valid_o,
  input  wire                                       out_stall_i,
  output logic        [15:0]                        motor_one_pos_o,
  output logic signed [14:0]                        motor_two_pos_o,
  output logic signed [14:0]                        motor_three_pos_o,
  output logic signed [14:0]                        motor_four_pos_o,
  output logic                                      in_startup_o
);

  localparam int unsigned AW = dapm_pkg::AngleW;
  localparam int unsigned SW = dapm_pkg::SumW;
  localparam int unsigned TW = dapm_pkg::TermW;

  // Configuration registers
  logic [dapm_pkg::GainW-1:0]  kp_pitch_q, ki_pitch_q, kd_pitch_q;
  logic [dapm_pkg::GainW-1:0]  kp_roll_q, ki_roll_q, kd_roll_q;
  logic [dapm_pkg::LimW-1:0]   clamp_limit_q;
  logic [dapm_pkg::TicksW-1:0] startup_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_pitch_q      <= dapm_pkg::KpReset;
      ki_pitch_q      <= dapm_pkg::KiReset;
      kd_pitch_q      <= dapm_pkg::KdReset;
      kp_roll_q       <= dapm_pkg::KpReset;
      ki_roll_q       <= dapm_pkg::KiReset;
      kd_roll_q       <= dapm_pkg::KdReset;
      clamp_limit_q   <= dapm_pkg::LimReset;
      startup_ticks_q <= dapm_pkg::TicksReset;
    end else if (cfg_we_i) begin
      unique case (dapm_pkg::cfg_reg_e'(cfg_idx_i))
        dapm_pkg::CfgKpPitch:      kp_pitch_q      <= cfg_wdata_i;
        dapm_pkg::CfgKiPitch:      ki_pitch_q      <= cfg_wdata_i;
        dapm_pkg::CfgKdPitch:      kd_pitch_q      <= cfg_wdata_i;
        dapm_pkg::CfgKpRoll:       kp_roll_q       <= cfg_wdata_i;
        dapm_pkg::CfgKiRoll:       ki_roll_q       <= cfg_wdata_i;
        dapm_pkg::CfgKdRoll:       kd_roll_q       <= cfg_wdata_i;
        dapm_pkg::CfgClampLimit:   clamp_limit_q   <= cfg_wdata_i[dapm_pkg::LimW-1:0];
        dapm_pkg::CfgStartupTicks: startup_ticks_q <= cfg_wdata_i[dapm_pkg::TicksW-1:0];
      endcase
    end
  end

  // Pipeline flow control
  logic v0_q, v1_q, v2_q, v3_q, out_valid_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  logic accept;
  dapm_pkg::stage_en_t en;

  assign rdy4       = !out_valid_q || !out_stall_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_stall_o = !rdy0;
  assign accept     = in_valid_i && rdy0;
  assign en.s1      = rdy1;
  assign en.s2      = rdy2;
  assign en.s3      = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy0) v0_q        <= in_valid_i;
      if (rdy1) v1_q        <= v0_q;
      if (rdy2) v2_q        <= v1_q;
      if (rdy3) v3_q        <= v2_q;
      if (rdy4) out_valid_q <= v3_q;
    end
  end

  // Controller state, advanced at each input transfer
  logic signed [AW-1:0] prev_pitch_q, prev_roll_q;
  logic signed [SW-1:0] pitch_sum_q, roll_sum_q, pitch_sum_d, roll_sum_d;
  logic [dapm_pkg::TickW-1:0] tick_q;
  logic startup;

  function automatic logic signed [SW-1:0] sat_add(logic signed [SW-1:0] acc,
                                                   logic signed [AW-1:0] x);
    logic signed [SW:0] s;
    s = (SW+1)'(acc) + (SW+1)'(x);
    if (s[SW] != s[SW-1]) begin
      sat_add = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sat_add = s[SW-1:0];
    end
  endfunction

  assign startup     = tick_q <= {1'b0, startup_ticks_q};
  assign pitch_sum_d = sat_add(pitch_sum_q, pitch_angle_i);
  assign roll_sum_d  = sat_add(roll_sum_q, roll_angle_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pitch_q <= '0;
      prev_roll_q  <= '0;
      pitch_sum_q  <= '0;
      roll_sum_q   <= '0;
      tick_q       <= '0;
    end else if (accept) begin
      prev_pitch_q <= pitch_angle_i;
      prev_roll_q  <= roll_angle_i;
      pitch_sum_q  <= pitch_sum_d;
      roll_sum_q   <= roll_sum_d;
      if (startup) tick_q <= tick_q + 1'b1;
    end
  end

  // Input register: sample plus the state it is computed against
  logic signed [AW-1:0] pitch0_q, roll0_q, prev_pitch0_q, prev_roll0_q;
  logic signed [SW-1:0] pitch_sum0_q, roll_sum0_q;
  logic st0_q, st1_q, st2_q, st3_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pitch0_q      <= pitch_angle_i;
      roll0_q       <= roll_angle_i;
      prev_pitch0_q <= prev_pitch_q;
      prev_roll0_q  <= prev_roll_q;
      pitch_sum0_q  <= pitch_sum_q;
      roll_sum0_q   <= roll_sum_q;
      st0_q         <= startup;
    end
    if (en.s1) st1_q <= st0_q;
    if (en.s2) st2_q <= st1_q;
    if (en.s3) st3_q <= st2_q;
  end

  logic signed [TW-1:0] term_pitch, term_roll;

  dapm_pid_axis u_pitch (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (pitch0_q),
    .prev_i (prev_pitch0_q),
    .sum_i  (pitch_sum0_q),
    .kp_i   (kp_pitch_q),
    .ki_i   (ki_pitch_q),
    .kd_i   (kd_pitch_q),
    .term_o (term_pitch)
  );

  dapm_pid_axis u_roll (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (roll0_q),
    .prev_i (prev_roll0_q),
    .sum_i  (roll_sum0_q),
    .kp_i   (kp_roll_q),
    .ki_i   (ki_roll_q),
    .kd_i   (kd_roll_q),
    .term_o (term_roll)
  );

  // Mix, clamp and offset; the mirrored mixes reuse the negated clamps
  function automatic logic signed [dapm_pkg::LimW:0] clamp_mix(
      logic signed [TW:0] v, logic [dapm_pkg::LimW-1:0] lim);
    logic signed [TW:0] lim_pos;
    lim_pos = $signed({{(TW+1-dapm_pkg::LimW){1'b0}}, lim});
    priority if (v > lim_pos) begin
      clamp_mix = $signed({1'b0, lim});
    end else if (v < -lim_pos) begin
      clamp_mix = -$signed({1'b0, lim});
    end else begin
      clamp_mix = v[dapm_pkg::LimW:0];
    end
  endfunction

  logic signed [TW:0] mix_diff, mix_sum;
  logic signed [dapm_pkg::LimW:0] c_diff, c_sum;
  logic signed [16:0] m1;
  logic        [15:0] motor_one_d, motor_one_q;
  logic signed [14:0] motor_two_d, motor_two_q;
  logic signed [14:0] motor_three_d, motor_three_q;
  logic signed [14:0] motor_four_d, motor_four_q;
  logic               startup_q;

  assign mix_diff = (TW+1)'(term_pitch) - (TW+1)'(term_roll);
  assign mix_sum  = (TW+1)'(term_pitch) + (TW+1)'(term_roll);
  assign c_diff   = st3_q ? '0 : clamp_mix(mix_diff, clamp_limit_q);
  assign c_sum    = st3_q ? '0 : clamp_mix(mix_sum, clamp_limit_q);

  assign m1            = dapm_pkg::OfsOne + 17'(c_diff);
  assign motor_one_d   = m1[15:0];
  assign motor_two_d   = dapm_pkg::OfsTwo + 15'(c_sum);
  assign motor_three_d = dapm_pkg::OfsThree - 15'(c_sum);
  assign motor_four_d  = dapm_pkg::OfsFour - 15'(c_diff);

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      motor_one_q   <= motor_one_d;
      motor_two_q   <= motor_two_d;
      motor_three_q <= motor_three_d;
      motor_four_q  <= motor_four_d;
      startup_q     <= st3_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign motor_one_pos_o   = motor_one_q;
  assign motor_two_pos_o   = motor_two_q;
  assign motor_three_pos_o = motor_three_q;
  assign motor_four_pos_o  = motor_four_q;
  assign in_startup_o      = startup_q;

`ifndef NO_ASSERTIONS
  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q <= 9'd256)
    else $error("tick counter ran past its saturation point");

  a_mix_two_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((16'(motor_two_pos_o) + 16'(motor_three_pos_o)) == -16'sd4000))
    else $error("motor two and three are not mirrored");

  a_mix_one_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({1'b0, motor_one_pos_o} + 17'(motor_four_pos_o)) == 17'd51100))
    else $error("motor one and four are not mirrored");

  a_startup_offsets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_startup_o) |-> (motor_one_pos_o == 16'd49100 &&
                                       motor_two_pos_o == -15'sd2000))
    else $error("startup result carries a correction");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && out_valid_q && out_stall_i) |=> v3_q)
    else $error("last stage dropped a sample under stall");
`endif

endmodule

`default_nettype wire
